/* sv/ldt_pkg.sv */
`default_nettype none
package ldt_pkg;

    localparam int LINE_MAX   = 1024;
    localparam int SMP_W      = 16;
    localparam int CNT_W      = $clog2(LINE_MAX + 1);
    localparam int ADR_W      = $clog2(LINE_MAX);
    localparam int SITE_DEPTH = LINE_MAX + 2;
    localparam int POS_W      = $clog2(SITE_DEPTH);
    localparam int G_W        = 2 * SMP_W;
    localparam int H_W        = G_W + 1;
    localparam int NUM_W      = H_W + 1;
    localparam int DEN_W      = POS_W + 1;
    localparam int MA_W       = NUM_W;
    localparam int MB_W       = SMP_W + 1;
    localparam int P_W        = MA_W + MB_W;

    localparam logic [SMP_W-1:0] NO_SITE   = '1;
    localparam logic [SMP_W-1:0] SAT_VALUE = NO_SITE - 1'b1;

    localparam logic [1:0] MODE_BIN  = 2'd0;
    localparam logic [1:0] MODE_SQR  = 2'd1;
    localparam logic [1:0] MODE_LIN  = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic REG_PASS_MODE = 1'b0;
    localparam logic REG_PAD_ENDS  = 1'b1;

    typedef struct packed {
        logic             go;
        logic [1:0]       mode;
        logic             pad;
        logic [CNT_W-1:0] cnt;
    } t_start;

    typedef struct packed {
        logic             we;
        logic [ADR_W-1:0] addr;
        logic [SMP_W-1:0] data;
    } t_ld;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [G_W-1:0]   g;
        logic [H_W-1:0]   h;
    } t_site;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } t_crs;

endpackage
`default_nettype wire

/* sv/ldt_mul.sv */
`default_nettype none
module ldt_mul (
    input  wire                          i_clk,
    input  wire logic signed [ldt_pkg::MA_W-1:0] i_a,
    input  wire logic signed [ldt_pkg::MB_W-1:0] i_b,
    output logic signed [ldt_pkg::P_W-1:0]       o_prod
);
    import ldt_pkg::*;

    logic signed [P_W-1:0] r_prod;

    // register every product before it is used
    always_ff @(posedge i_clk) begin
        r_prod <= P_W'(i_a) * P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

/* sv/ldt_engine.sv */
`default_nettype none
module ldt_engine (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire ldt_pkg::t_start         i_start,
    input  wire ldt_pkg::t_ld            i_ld,
    input  wire                          i_res_re,
    input  wire [ldt_pkg::ADR_W-1:0]     i_res_ra,
    output logic [ldt_pkg::SMP_W-1:0]    o_res_q,
    output logic                         o_done
);
    import ldt_pkg::*;

    typedef enum logic [3:0] {
        E_IDLE, E_RD, E_VAL, E_G, E_H, E_CR, E_M0, E_M1, E_M2, E_PUSH,
        Q_RD, Q_VAL, Q_CMP, Q_DX, Q_SUM
    } t_state;

    t_state r_state;
    logic   r_done;

    logic [1:0]       r_mode;
    logic             r_pad;
    logic [CNT_W-1:0] r_cnt;
    logic [POS_W-1:0] r_q;
    logic [POS_W-1:0] r_top;
    logic [POS_W-1:0] r_j;
    logic             r_any;
    logic             r_padpos;
    logic [SMP_W-1:0] r_v;
    logic [G_W-1:0]   r_g;
    logic [H_W-1:0]   r_h;
    logic signed [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic signed [P_W-1:0] r_p1;

    // memories
    logic [SMP_W-1:0] smp_mem [LINE_MAX];
    t_site            site_mem [SITE_DEPTH];
    t_crs             crs_mem [SITE_DEPTH];
    logic [SMP_W-1:0] res_mem [LINE_MAX];
    logic [SMP_W-1:0] r_smp_q;
    t_site            r_site_q;
    t_crs             r_crs_q;
    logic [SMP_W-1:0] r_res_q;

    logic             smp_re;
    logic [ADR_W-1:0] smp_ra;
    logic             site_re, site_we;
    logic [POS_W-1:0] site_ra, site_wa;
    t_site            site_wd;
    logic             crs_re, crs_we;
    logic [POS_W-1:0] crs_ra, crs_wa;
    t_crs             crs_wd;
    logic             res_we;
    logic [ADR_W-1:0] res_wa;
    logic [SMP_W-1:0] res_wd;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  prod;

    logic [POS_W-1:0] len_m1;
    logic [POS_W-1:0] q_end;
    logic             q_last;
    logic             qry_last;
    logic [ADR_W-1:0] line_idx;
    logic [SMP_W-1:0] v_env;
    logic             site_ok;
    logic [G_W-1:0]   g_sel;
    logic [H_W-1:0]   h_sum;
    logic signed [NUM_W-1:0] num_c;
    logic [DEN_W-1:0] den_c;
    logic             pop;
    logic             adv_j;
    logic signed [POS_W:0] dx;
    logic [SMP_W-1:0] abs_dx;
    logic signed [P_W-1:0] sum;
    logic [SMP_W-1:0] sum_sat;

    ldt_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // line geometry and datapath terms
    always_comb begin
        len_m1   = POS_W'(r_cnt) + (r_pad ? POS_W'(2) : '0) - 1'b1;
        q_end    = POS_W'(r_cnt) + POS_W'(r_pad) - 1'b1;
        q_last   = (r_q == len_m1);
        qry_last = (r_q == q_end);
        line_idx = ADR_W'(r_q - POS_W'(r_pad));
        v_env    = r_padpos ? '0 : r_smp_q;
        site_ok  = (r_mode == MODE_BIN) ? (v_env == '0) : (v_env != NO_SITE);
        case (r_mode)
            MODE_BIN: g_sel = '0;
            MODE_SQR: g_sel = prod[G_W-1:0];
            default:  g_sel = G_W'(r_v);
        endcase
        h_sum   = H_W'(r_g) + prod[H_W-1:0];
        num_c   = $signed({1'b0, r_h}) - $signed({1'b0, r_site_q.h});
        den_c   = {r_q - r_site_q.pos, 1'b0};
        pop     = (r_p1 <= prod);
        adv_j   = (P_W'($signed(r_crs_q.num)) < prod);
        dx      = $signed({1'b0, r_q}) - $signed({1'b0, r_site_q.pos});
        abs_dx  = dx[POS_W] ? SMP_W'(-dx) : SMP_W'(dx);
        sum     = prod + $signed(P_W'(r_site_q.g));
        sum_sat = (sum > $signed(P_W'(NO_SITE))) ? SAT_VALUE : sum[SMP_W-1:0];
    end

    // memory controls and multiplier operands
    always_comb begin
        smp_re  = 1'b0;
        smp_ra  = line_idx;
        site_re = 1'b0;
        site_ra = r_top;
        site_we = 1'b0;
        site_wa = r_top + 1'b1;
        site_wd = '{pos: r_q, g: r_g, h: r_h};
        crs_re  = 1'b0;
        crs_ra  = r_top;
        crs_we  = 1'b0;
        crs_wa  = r_top + 1'b1;
        crs_wd  = '{num: r_num, den: r_den};
        res_we  = 1'b0;
        res_wa  = line_idx;
        res_wd  = r_smp_q;
        mul_a   = MA_W'(r_q);
        mul_b   = MB_W'(r_q);
        case (r_state)
            E_RD: begin
                smp_re = 1'b1;
            end
            E_VAL: begin
                mul_a = MA_W'(v_env);
                mul_b = MB_W'(v_env);
            end
            E_H: begin
                if (!r_any) begin
                    site_we = 1'b1;
                    site_wa = '0;
                    site_wd = '{pos: r_q, g: r_g, h: h_sum};
                end else begin
                    site_re = 1'b1;
                    crs_re  = 1'b1;
                end
            end
            E_M0: begin
                mul_a = r_num;
                mul_b = MB_W'(r_crs_q.den);
            end
            E_M1: begin
                mul_a = $signed(r_crs_q.num);
                mul_b = MB_W'(r_den);
            end
            E_M2: begin
                if (pop) begin
                    site_re = 1'b1;
                    crs_re  = 1'b1;
                    site_ra = r_top - 1'b1;
                    crs_ra  = r_top - 1'b1;
                end
            end
            E_PUSH: begin
                site_we = 1'b1;
                crs_we  = 1'b1;
            end
            Q_RD: begin
                smp_re  = 1'b1;
                site_re = 1'b1;
                site_ra = r_j;
                crs_re  = 1'b1;
                crs_ra  = r_j + 1'b1;
            end
            Q_VAL: begin
                mul_b = MB_W'(r_crs_q.den);
                if (!r_any) begin
                    res_we = 1'b1;
                end else if (r_smp_q == '0) begin
                    res_we = 1'b1;
                    res_wd = '0;
                end
            end
            Q_DX: begin
                mul_a = MA_W'(dx);
                mul_b = MB_W'(dx);
                if (r_mode == MODE_BIN) begin
                    res_we = 1'b1;
                    res_wd = abs_dx;
                end
            end
            Q_SUM: begin
                res_we = 1'b1;
                res_wd = sum_sat;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                E_IDLE: begin
                    if (i_start.go) begin
                        r_mode  <= (i_start.mode == MODE_RSVD) ? MODE_LIN : i_start.mode;
                        r_pad   <= i_start.pad;
                        r_cnt   <= i_start.cnt;
                        r_q     <= '0;
                        r_any   <= 1'b0;
                        r_top   <= '0;
                        r_state <= E_RD;
                    end
                end
                E_RD: begin
                    r_padpos <= r_pad && (r_q == '0 || q_last);
                    r_state  <= E_VAL;
                end
                E_VAL: begin
                    r_v <= v_env;
                    if (site_ok) begin
                        r_state <= E_G;
                    end else if (q_last) begin
                        r_q     <= POS_W'(r_pad);
                        r_j     <= '0;
                        r_state <= Q_RD;
                    end else begin
                        r_q     <= r_q + 1'b1;
                        r_state <= E_RD;
                    end
                end
                E_G: begin
                    r_g     <= g_sel;
                    r_state <= E_H;
                end
                E_H: begin
                    r_h <= h_sum;
                    if (r_any) begin
                        r_state <= E_CR;
                    end else begin
                        r_any <= 1'b1;
                        r_top <= '0;
                        if (q_last) begin
                            r_q     <= POS_W'(r_pad);
                            r_j     <= '0;
                            r_state <= Q_RD;
                        end else begin
                            r_q     <= r_q + 1'b1;
                            r_state <= E_RD;
                        end
                    end
                end
                E_CR: begin
                    r_num   <= num_c;
                    r_den   <= den_c;
                    r_state <= (r_top == '0) ? E_PUSH : E_M0;
                end
                E_M0: begin
                    r_state <= E_M1;
                end
                E_M1: begin
                    r_p1    <= prod;
                    r_state <= E_M2;
                end
                E_M2: begin
                    if (pop) begin
                        r_top   <= r_top - 1'b1;
                        r_state <= E_CR;
                    end else begin
                        r_state <= E_PUSH;
                    end
                end
                E_PUSH: begin
                    r_top <= r_top + 1'b1;
                    if (q_last) begin
                        r_q     <= POS_W'(r_pad);
                        r_j     <= '0;
                        r_state <= Q_RD;
                    end else begin
                        r_q     <= r_q + 1'b1;
                        r_state <= E_RD;
                    end
                end
                Q_RD: begin
                    r_state <= Q_VAL;
                end
                Q_VAL: begin
                    if (!r_any || r_smp_q == '0) begin
                        if (qry_last) begin
                            r_done  <= 1'b1;
                            r_state <= E_IDLE;
                        end else begin
                            r_q     <= r_q + 1'b1;
                            r_state <= Q_RD;
                        end
                    end else if (r_j < r_top) begin
                        r_state <= Q_CMP;
                    end else begin
                        r_state <= Q_DX;
                    end
                end
                Q_CMP: begin
                    if (adv_j) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= Q_RD;
                    end else begin
                        r_state <= Q_DX;
                    end
                end
                Q_DX: begin
                    if (r_mode != MODE_BIN) begin
                        r_state <= Q_SUM;
                    end else if (qry_last) begin
                        r_done  <= 1'b1;
                        r_state <= E_IDLE;
                    end else begin
                        r_q     <= r_q + 1'b1;
                        r_state <= Q_RD;
                    end
                end
                Q_SUM: begin
                    if (qry_last) begin
                        r_done  <= 1'b1;
                        r_state <= E_IDLE;
                    end else begin
                        r_q     <= r_q + 1'b1;
                        r_state <= Q_RD;
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    // sample store: loads write, sequencer reads
    always_ff @(posedge i_clk) begin
        if (i_ld.we) begin
            smp_mem[i_ld.addr] <= i_ld.data;
        end
        if (smp_re) begin
            r_smp_q <= smp_mem[smp_ra];
        end
    end

    // envelope site store
    always_ff @(posedge i_clk) begin
        if (site_we) begin
            site_mem[site_wa] <= site_wd;
        end
        if (site_re) begin
            r_site_q <= site_mem[site_ra];
        end
    end

    // envelope crossing store
    always_ff @(posedge i_clk) begin
        if (crs_we) begin
            crs_mem[crs_wa] <= crs_wd;
        end
        if (crs_re) begin
            r_crs_q <= crs_mem[crs_ra];
        end
    end

    // result store
    always_ff @(posedge i_clk) begin
        if (res_we) begin
            res_mem[res_wa] <= res_wd;
        end
        if (i_res_re) begin
            r_res_q <= res_mem[i_res_ra];
        end
    end

    assign o_res_q = r_res_q;
    assign o_done  = r_done;

endmodule
`default_nettype wire

/* sv/line_distance_transform.sv */
// Line pass of a separable distance transform.
// Input channel (i_in_valid / o_in_ready): each transaction is a command.
// A load (i_cmd 0) writes one sample; samples past the line
// limit are dropped. A load with i_line_last closes the line, and the block
// then builds the lower envelope and scans it for every loaded position.
// Both passes share the one multiplier, and each store has a single read
// port; o_in_ready is low throughout.
// A read (i_cmd 1) returns one result on the output channel
// (o_out_valid / i_out_ready) via the result store read and the S_RD state,
// or in the next cycle when nothing is pending (o_none_left set). A read
// is held off while an earlier result still waits for the receiver; a load
// is not. A load while results are pending drops them and starts a new line.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready; pass mode and
// end padding are sampled when the line closes.
// Reset clears the line count, the read pointer and the pending flag; the
// stores keep no reset value and need no clearing pass.
`default_nettype none
module line_distance_transform (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_cmd,
    input  wire [15:0]  i_sample_value,
    input  wire         i_line_last,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [15:0] o_distance,
    output logic        o_line_end,
    output logic        o_none_left,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire [1:0]   i_cfg_data
);
    import ldt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_RD} t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_rp;
    logic             r_rdy;
    logic [1:0]       r_mode;
    logic             r_pad;
    logic             r_out_valid;
    logic [SMP_W-1:0] r_dist;
    logic             r_end;
    logic             r_none;
    logic             r_end_pend;

    logic             in_acc;
    logic [CNT_W-1:0] eff_cnt;
    logic [CNT_W-1:0] new_cnt;
    t_start           start;
    t_ld              ld;
    logic             res_re;
    logic [SMP_W-1:0] res_q;
    logic             done;

    assign o_in_ready  = (r_state == S_IDLE) && (i_cmd == CMD_LOAD || !r_out_valid);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;

    // load bookkeeping
    always_comb begin
        eff_cnt    = r_rdy ? '0 : r_cnt;
        new_cnt    = (eff_cnt < CNT_W'(LINE_MAX)) ? eff_cnt + 1'b1 : eff_cnt;
        ld.we      = in_acc && i_cmd == CMD_LOAD && eff_cnt < CNT_W'(LINE_MAX);
        ld.addr    = eff_cnt[ADR_W-1:0];
        ld.data    = i_sample_value;
        start.go   = in_acc && i_cmd == CMD_LOAD && i_line_last;
        start.mode = r_mode;
        start.pad  = r_pad;
        start.cnt  = new_cnt;
        res_re     = in_acc && i_cmd == CMD_READ && r_rdy;
    end

    ldt_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_ld     (ld),
        .i_res_re (res_re),
        .i_res_ra (r_rp[ADR_W-1:0]),
        .o_res_q  (res_q),
        .o_done   (done)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BIN;
            r_pad  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PASS_MODE: r_mode <= i_cfg_data;
                REG_PAD_ENDS:  r_pad  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // command sequencing and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rp        <= '0;
            r_rdy       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_cmd == CMD_LOAD) begin
                        r_rdy <= 1'b0;
                        r_rp  <= '0;
                        r_cnt <= new_cnt;
                        if (i_line_last) begin
                            r_state <= S_CALC;
                        end
                    end else if (in_acc) begin
                        if (r_rdy) begin
                            r_end_pend <= (r_rp + 1'b1 == r_cnt);
                            r_state    <= S_RD;
                            if (r_rp + 1'b1 == r_cnt) begin
                                r_rdy <= 1'b0;
                                r_cnt <= '0;
                                r_rp  <= '0;
                            end else begin
                                r_rp <= r_rp + 1'b1;
                            end
                        end else begin
                            r_out_valid <= 1'b1;
                            r_dist      <= '0;
                            r_end       <= 1'b0;
                            r_none      <= 1'b1;
                        end
                    end
                end
                S_CALC: begin
                    if (done) begin
                        r_rdy   <= 1'b1;
                        r_rp    <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_out_valid <= 1'b1;
                    r_dist      <= res_q;
                    r_end       <= r_end_pend;
                    r_none      <= 1'b0;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_dist;
    assign o_line_end  = r_end;
    assign o_none_left = r_none;

    a_rp_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdy |-> (r_rp < r_cnt))
        else $error("read pointer beyond loaded line");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(LINE_MAX))
        else $error("line count beyond limit");

    a_none_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_cmd == CMD_READ && !r_rdy) |=> (r_out_valid && r_none))
        else $error("empty read gave no none-left result");

    a_close_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start.go |=> (r_state == S_CALC && !r_rdy))
        else $error("line close did not start the pass");

endmodule
`default_nettype wire

/* bench/tb_line_distance_transform.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_line_distance_transform;
    import ldt_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int ITEM_TARGET    = 1150;

    typedef struct packed {
        logic        cmd;
        logic [15:0] sample;
        logic        last;
        logic        typed;
        logic [15:0] dval;
        logic        lend;
        logic        none;
    } t_row;

    typedef struct packed {
        logic [15:0] dval;
        logic        lend;
        logic        none;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_cmd = CMD_LOAD;
    logic [15:0] i_sample_value = '0;
    logic        i_line_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_distance;
    logic        o_line_end;
    logic        o_none_left;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = REG_PASS_MODE;
    logic [1:0]  i_cfg_data = '0;

    // typed expectation riding along with the current transaction
    logic        typed_en = 1'b0;
    t_res        typed_res = '0;

    line_distance_transform dut (.*);

    always #1 i_clk = ~i_clk;

    // line model state
    logic [15:0] line_smp [0:LINE_MAX+1];
    int          env_site [0:LINE_MAX+2];
    longint      env_num  [0:LINE_MAX+2];
    longint      env_den  [0:LINE_MAX+2];
    logic [15:0] line_dist [0:LINE_MAX+1];
    int          load_cnt = 0;
    int          rd_ptr = 0;
    bit          pending = 0;
    logic [1:0]  cur_mode = MODE_BIN;
    bit          cur_pad = 0;

    t_res        expected_q [$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;

    function automatic int value_at(int pos, int pad, int len);
        if (pad != 0 && (pos == 0 || pos + 1 == len)) return 0;
        return line_smp[pos - pad];
    endfunction

    function automatic bit is_site(int v, int mode);
        return mode == 0 ? v == 0 : v != 32'hFFFF;
    endfunction

    function automatic longint site_offset(int v, int mode);
        if (mode == 0) return 0;
        if (mode == 1) return longint'(v) * longint'(v);
        return longint'(v);
    endfunction

    // lower envelope of the site parabolas, then a scan over the line
    function automatic void compute_line();
        int     mode, pad, len, top, j, v, sv;
        bit     any;
        longint num, den, dx, sum;
        mode = (cur_mode == MODE_RSVD) ? 2 : int'(cur_mode);
        pad = cur_pad;
        len = load_cnt + 2 * pad;
        top = 0;
        j = 0;
        any = 0;
        for (int q = 0; q < len; q++) begin
            v = value_at(q, pad, len);
            if (!is_site(v, mode)) continue;
            if (!any) begin
                any = 1;
                top = 0;
                env_site[0] = q;
                continue;
            end
            sv = value_at(env_site[top], pad, len);
            num = site_offset(v, mode) + longint'(q) * q - site_offset(sv, mode)
                  - longint'(env_site[top]) * env_site[top];
            den = 2 * (longint'(q) - env_site[top]);
            while (top > 0 && num * env_den[top] <= env_num[top] * den) begin
                top--;
                sv = value_at(env_site[top], pad, len);
                num = site_offset(v, mode) + longint'(q) * q - site_offset(sv, mode)
                      - longint'(env_site[top]) * env_site[top];
                den = 2 * (longint'(q) - env_site[top]);
            end
            top++;
            env_site[top] = q;
            env_num[top] = num;
            env_den[top] = den;
        end
        for (int q = pad; q < pad + load_cnt; q++) begin
            v = value_at(q, pad, len);
            if (!any) begin
                line_dist[q - pad] = v[15:0];
            end else if (v == 0) begin
                line_dist[q - pad] = '0;
            end else begin
                while (j < top && env_num[j + 1] < longint'(q) * env_den[j + 1]) j++;
                dx = longint'(q) - env_site[j];
                if (mode == 0) begin
                    line_dist[q - pad] = (dx < 0) ? 16'(-dx) : 16'(dx);
                end else begin
                    sum = dx * dx + site_offset(value_at(env_site[j], pad, len), mode);
                    line_dist[q - pad] = (sum > 65535) ? SAT_VALUE : 16'(sum);
                end
            end
        end
    endfunction

    // advance the line model by one command; returns 1 when a result is due
    function automatic bit line_step(logic cmd, logic [15:0] smp, logic last,
                                     output t_res r);
        r = '0;
        if (cmd == CMD_LOAD) begin
            if (pending) begin
                pending = 0;
                load_cnt = 0;
                rd_ptr = 0;
            end
            if (load_cnt < LINE_MAX) begin
                line_smp[load_cnt] = smp;
                load_cnt++;
            end
            if (last) begin
                compute_line();
                pending = 1;
                rd_ptr = 0;
            end
            return 0;
        end
        if (pending && rd_ptr < load_cnt) begin
            r.dval = line_dist[rd_ptr];
            r.lend = (rd_ptr + 1 == load_cnt);
            rd_ptr++;
            if (r.lend) begin
                pending = 0;
                load_cnt = 0;
                rd_ptr = 0;
            end
        end else begin
            r.none = 1'b1;
        end
        return 1;
    endfunction

    // predict on each accepted command and config write
    always @(posedge i_clk) begin
        t_res r;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_PASS_MODE) cur_mode = i_cfg_data;
            else cur_pad = i_cfg_data[0];
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            if (line_step(i_cmd, i_sample_value, i_line_last, r))
                expected_q.push_back(typed_en ? typed_res : r);
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: dist %0d end %0b none %0b",
                             o_distance, o_line_end, o_none_left);
            end else begin
                e = expected_q.pop_front();
                if (e.dval !== o_distance || e.lend !== o_line_end
                    || e.none !== o_none_left) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp dist %0d end %0b none %0b, got %0d %0b %0b",
                                 e.dval, e.lend, e.none, o_distance, o_line_end,
                                 o_none_left);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls, gap-free stretches and two long hold-offs
    initial begin
        int n_taken;
        int hold;
        n_taken = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (n_taken == 20 || n_taken == 40) hold = 400;
            else if ((n_taken / 64) % 3 == 1) hold = 0;
            else hold = $urandom_range(0, 15);
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            n_taken++;
        end
    end

    task automatic send_cmd(logic cmd, logic [15:0] smp, logic last,
                            logic has_typed = 1'b0, t_res tr = '0);
        int gap;
        gap = ((items_sent / 80) % 4 == 2) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_sample_value <= smp;
        i_line_last <= last;
        typed_en <= has_typed;
        typed_res <= tr;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // hold until every expected result is back and the block has settled
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] draw_sample();
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'd0;
            3, 4:    return NO_SITE;
            5:       return 16'($urandom_range(0, 300));
            6:       return ($urandom_range(0, 1) != 0) ? SAT_VALUE : 16'd256;
            7:       return 16'($urandom_range(250, 260));
            default: return 16'($urandom);
        endcase
    endfunction

    // one line with random content, then reads; sometimes short or extra reads
    task automatic random_line(int len);
        int n_rd;
        if ($urandom_range(0, 9) == 0) send_cmd(CMD_READ, 16'($urandom), 1'($urandom));
        for (int k = 0; k < len; k++)
            send_cmd(CMD_LOAD, draw_sample(), k == len - 1);
        case ($urandom_range(0, 9))
            0:       n_rd = $urandom_range(0, len);
            1:       n_rd = len + 3;
            default: n_rd = len + 1;
        endcase
        for (int k = 0; k < n_rd; k++)
            send_cmd(CMD_READ, 16'($urandom), 1'($urandom));
    endtask

    t_row dir_tab [0:18];

    initial begin
        logic [1:0] modes [0:6];
        logic       pads  [0:6];
        dir_tab = '{
            '{CMD_READ, 16'd0,     1'b0, 1'b1, 16'd0,     1'b0, 1'b1},
            '{CMD_LOAD, NO_SITE,   1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
            '{CMD_LOAD, 16'd0,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
            '{CMD_LOAD, NO_SITE,   1'b1, 1'b0, 16'd0,     1'b0, 1'b0},
            '{CMD_READ, 16'hFFFF,  1'b1, 1'b1, 16'd1,     1'b0, 1'b0},
            '{CMD_READ, 16'h0000,  1'b0, 1'b1, 16'd0,     1'b0, 1'b0},
            '{CMD_READ, 16'h5A5A,  1'b0, 1'b1, 16'd1,     1'b1, 1'b0},
            '{CMD_READ, 16'hA5A5,  1'b1, 1'b1, 16'd0,     1'b0, 1'b1},
            '{CMD_LOAD, NO_SITE,   1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
            '{CMD_LOAD, 16'd12345, 1'b1, 1'b0, 16'd0,     1'b0, 1'b0},
            '{CMD_READ, 16'd0,     1'b0, 1'b1, NO_SITE,   1'b0, 1'b0},
            '{CMD_READ, 16'd0,     1'b0, 1'b1, 16'd12345, 1'b1, 1'b0},
            '{CMD_LOAD, 16'd0,     1'b1, 1'b0, 16'd0,     1'b0, 1'b0},
            '{CMD_LOAD, 16'd7,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
            '{CMD_LOAD, 16'd0,     1'b1, 1'b0, 16'd0,     1'b0, 1'b0},
            '{CMD_READ, 16'd0,     1'b0, 1'b1, 16'd1,     1'b0, 1'b0},
            '{CMD_LOAD, SAT_VALUE, 1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
            '{CMD_LOAD, 16'h8001,  1'b1, 1'b0, 16'd0,     1'b0, 1'b0},
            '{CMD_READ, 16'd0,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0}
        };
        modes = '{MODE_SQR, MODE_LIN, MODE_RSVD, MODE_BIN, MODE_SQR, MODE_LIN, MODE_BIN};
        pads  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(REG_PASS_MODE, MODE_BIN);
        write_reg(REG_PAD_ENDS, 2'd0);

        // directed rows in binary mode without padding
        foreach (dir_tab[r])
            send_cmd(dir_tab[r].cmd, dir_tab[r].sample, dir_tab[r].last, dir_tab[r].typed,
                     '{dir_tab[r].dval, dir_tab[r].lend, dir_tab[r].none});
        send_cmd(CMD_READ, 16'd0, 1'b0);
        send_cmd(CMD_READ, 16'd0, 1'b0);
        drain();

        // overlong line with saturating squares; drop loads past the limit,
        // read the head of the line and leave the rest for the next load to drop
        write_reg(REG_PASS_MODE, MODE_SQR);
        write_reg(REG_PAD_ENDS, 2'd1);
        for (int k = 0; k < LINE_MAX + 3; k++)
            send_cmd(CMD_LOAD, draw_sample(), k == LINE_MAX + 2);
        for (int k = 0; k < 6; k++)
            send_cmd(CMD_READ, 16'($urandom), 1'($urandom));
        drain();

        // random lines across the register settings
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(REG_PASS_MODE, modes[ph]);
            write_reg(REG_PAD_ENDS, {1'b0, pads[ph]});
            while (items_sent < ITEM_TARGET - 100 + 100 * (ph + 1) / 7) begin
                if ($urandom_range(0, 15) == 0) random_line($urandom_range(30, 70));
                else random_line($urandom_range(1, 12));
            end
            send_cmd(CMD_READ, 16'd0, 1'b0);
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
sv/ldt_pkg.sv
sv/ldt_mul.sv
sv/ldt_engine.sv
sv/line_distance_transform.sv
bench/tb_line_distance_transform.sv
